// File: src/krd_pkg.sv
// ----------------------------------------------------------------------------
// krd_pkg
// Shared types and codes for the keyed record deque: request modes, result
// status codes, cell commands, the record layout and the sequencer states.
// ----------------------------------------------------------------------------
package krd_pkg;

    localparam int KEY_W     = 32;
    localparam int TKT_W     = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 5;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_HEAD     = 3'd0,
        MODE_PUSH_TAIL     = 3'd1,
        MODE_POP_HEAD      = 3'd2,
        MODE_POP_TAIL      = 3'd3,
        MODE_SEARCH        = 3'd4,
        MODE_REMOVE_BEFORE = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_HEAD,   // take left neighbor, cell 0 takes the new record
        CMD_PUSH_TAIL,   // cell at the broadcast position takes the new record
        CMD_ROTATE,      // take right neighbor, last cell takes cell 0
        CMD_DROP         // cells at or past the broadcast position take right
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TKT_W-1:0] tkt;
    } t_rec;

    typedef struct packed {
        t_cmd cmd;
        t_rec rec;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// File: src/keyed_record_deque.sv
// ----------------------------------------------------------------------------
// keyed_record_deque
// Ordered list of up to DEPTH key/ticket records with push and pop at both
// ends, key search and remove-before-match, built as a chain of cells.
// ----------------------------------------------------------------------------
// Each input beat carries one request (mode in tuser, key and ticket in tdata)
// and produces exactly one result beat (status in tuser, record and entry
// count in tdata). Push head, push tail, pop head, unused mode codes and any
// request on an empty list finish in the accept cycle: one beat per cycle while
// the result stream does not stall. Pop tail, search and remove-before rotate
// the whole cell ring once so that every slot passes the fixed read point at
// cell 0: an accept step, a rotate step per ring slot, then a finish step that
// waits for a free output register. A finished result sits in the output
// register while the next request is accepted. Slots hold no reset value;
// only slots below the fill count are ever observed.
// ----------------------------------------------------------------------------
module keyed_record_deque #(
    parameter int DEPTH = krd_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] key, [63:32] ticket
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] mode
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] rec_key, [63:32] rec_ticket,
                                          // [68:64] entries, [71:69] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CW + krd_pkg::ENTRIES_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    krd_pkg::t_state  r_state,   n_state;
    logic [CW-1:0]    r_count,   n_count;
    logic [IW-1:0]    r_step,    n_step;
    krd_pkg::t_mode   r_mode,    n_mode;
    logic [31:0]      r_key,     n_key;
    logic             r_found,   n_found;
    logic [IW-1:0]    r_pos,     n_pos;
    krd_pkg::t_rec    r_hit,     n_hit;
    krd_pkg::t_rec    r_hitprev, n_hitprev;
    krd_pkg::t_rec    r_prev,    n_prev;

    // Output register
    logic             r_out_valid,   n_out_valid;
    krd_pkg::t_status r_out_status,  n_out_status;
    krd_pkg::t_rec    r_out_rec,     n_out_rec;
    logic [4:0]       r_out_entries, n_out_entries;

    // Cell chain wiring
    krd_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0]      w_pos;
    krd_pkg::t_rec      w_cell  [DEPTH];
    krd_pkg::t_rec      w_left  [DEPTH];
    krd_pkg::t_rec      w_right [DEPTH];

    logic               w_accept;
    logic               w_out_free;
    krd_pkg::t_mode     w_in_mode;
    krd_pkg::t_rec      w_in_rec;
    logic [EW-1:0]      w_cnt_wide;

    assign w_in_mode    = krd_pkg::t_mode'(i_s_axis_tuser);
    assign w_in_rec.key = i_s_axis_tdata[31:0];
    assign w_in_rec.tkt = i_s_axis_tdata[63:32];
    assign w_out_free   = !r_out_valid || i_m_axis_tready;
    assign w_accept     = i_s_axis_tvalid && o_s_axis_tready;
    // entries field reports the count masked to five bits
    assign w_cnt_wide   = EW'(n_count);

    // ------------------------------------------------------------------------
    // Chain of cells: cell 0 is the head
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = w_ctl.rec;
        end else begin : g_body
            assign w_left[g] = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_wrap
            assign w_right[g] = w_cell[0];
        end else begin : g_next
            assign w_right[g] = w_cell[g+1];
        end

        krd_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_rec   (w_cell[g])
        );
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state, cell command and result
    // ------------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_step        = r_step;
        n_mode        = r_mode;
        n_key         = r_key;
        n_found       = r_found;
        n_pos         = r_pos;
        n_hit         = r_hit;
        n_hitprev     = r_hitprev;
        n_prev        = r_prev;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_status  = r_out_status;
        n_out_rec     = r_out_rec;
        n_out_entries = r_out_entries;
        o_s_axis_tready = 1'b0;
        w_ctl.cmd     = krd_pkg::CMD_HOLD;
        w_ctl.rec     = w_in_rec;
        w_pos         = '0;

        case (r_state)
            krd_pkg::S_IDLE: begin
                o_s_axis_tready = w_out_free;
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_status = krd_pkg::ST_OK;
                    n_out_rec    = '0;
                    case (w_in_mode)
                        krd_pkg::MODE_PUSH_HEAD: begin
                            if (r_count >= FULL_CNT) begin
                                n_out_status = krd_pkg::ST_FULL;
                            end else begin
                                w_ctl.cmd = krd_pkg::CMD_PUSH_HEAD;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        krd_pkg::MODE_PUSH_TAIL: begin
                            if (r_count >= FULL_CNT) begin
                                n_out_status = krd_pkg::ST_FULL;
                            end else begin
                                w_ctl.cmd = krd_pkg::CMD_PUSH_TAIL;
                                w_pos     = r_count[IW-1:0];
                                n_count   = r_count + 1'b1;
                            end
                        end
                        krd_pkg::MODE_POP_HEAD: begin
                            if (r_count == '0) begin
                                n_out_status = krd_pkg::ST_EMPTY;
                            end else begin
                                n_out_rec = w_cell[0];
                                w_ctl.cmd = krd_pkg::CMD_DROP;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        krd_pkg::MODE_POP_TAIL,
                        krd_pkg::MODE_SEARCH,
                        krd_pkg::MODE_REMOVE_BEFORE: begin
                            if (r_count == '0) begin
                                n_out_status = krd_pkg::ST_EMPTY;
                            end else begin
                                // hold the result back until the ring turns once
                                n_out_valid = r_out_valid && !i_m_axis_tready;
                                n_state     = krd_pkg::S_SCAN;
                                n_mode      = w_in_mode;
                                n_key       = w_in_rec.key;
                                n_step      = '0;
                                n_found     = 1'b0;
                                n_hit       = '0;
                            end
                        end
                        default: n_out_status = krd_pkg::ST_NOMATCH;
                    endcase
                    n_out_entries = w_cnt_wide[4:0];
                end
            end

            krd_pkg::S_SCAN: begin
                // advance the ring; cell 0 now shows original slot r_step
                w_ctl.cmd = krd_pkg::CMD_ROTATE;
                n_prev    = w_cell[0];
                if (r_mode == krd_pkg::MODE_POP_TAIL) begin
                    if (CW'(r_step) == r_count - 1'b1) begin
                        n_hit   = w_cell[0];
                        n_found = 1'b1;
                    end
                end else if (!r_found && (CW'(r_step) < r_count)
                             && (w_cell[0].key == r_key)) begin
                    n_found   = 1'b1;
                    n_pos     = r_step;
                    n_hit     = w_cell[0];
                    n_hitprev = r_prev;
                end
                if (r_step == LAST_IDX) begin
                    n_state = krd_pkg::S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end

            krd_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state      = krd_pkg::S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = krd_pkg::ST_NOMATCH;
                    n_out_rec    = '0;
                    case (r_mode)
                        krd_pkg::MODE_POP_TAIL: begin
                            n_out_status = krd_pkg::ST_OK;
                            n_out_rec    = r_hit;
                            n_count      = r_count - 1'b1;
                        end
                        krd_pkg::MODE_SEARCH: begin
                            if (r_found) begin
                                n_out_status = krd_pkg::ST_OK;
                                n_out_rec    = r_hit;
                            end
                        end
                        krd_pkg::MODE_REMOVE_BEFORE: begin
                            // drop the record just ahead of the match
                            if (r_found && (r_pos != '0)) begin
                                n_out_status = krd_pkg::ST_OK;
                                n_out_rec    = r_hitprev;
                                w_ctl.cmd    = krd_pkg::CMD_DROP;
                                w_pos        = r_pos - 1'b1;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        default: n_out_status = krd_pkg::ST_NOMATCH;
                    endcase
                    n_out_entries = w_cnt_wide[4:0];
                end
            end

            default: n_state = krd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krd_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_key         <= n_key;
        r_pos         <= n_pos;
        r_hit         <= n_hit;
        r_hitprev     <= n_hitprev;
        r_prev        <= n_prev;
        r_out_status  <= n_out_status;
        r_out_rec     <= n_out_rec;
        r_out_entries <= n_out_entries;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'b000, r_out_entries, r_out_rec.tkt, r_out_rec.key};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count beyond depth");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != krd_pkg::S_IDLE) |-> !o_s_axis_tready)
        else $error("request taken while a scan is running");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == krd_pkg::MODE_PUSH_HEAD) && (r_count < FULL_CNT))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push head did not grow the list");

    a_full_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == krd_pkg::ST_FULL))
        |-> (o_m_axis_tdata[68:64] == 5'(DEPTH)))
        else $error("full status with a short list");

    a_scan_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == krd_pkg::S_SCAN) |-> (r_step == '0))
        else $error("scan started at a nonzero step");
`endif

endmodule

// File: src/krd_cell.sv
// ----------------------------------------------------------------------------
// krd_cell
// One slot of the record chain. Holds a key and a ticket and moves them to or
// from its neighbors as the broadcast command directs.
// ----------------------------------------------------------------------------
module krd_cell #(
    parameter int DEPTH = krd_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                     i_clk,
    input  krd_pkg::t_cell_ctl       i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_pos,
    input  krd_pkg::t_rec            i_left,
    input  krd_pkg::t_rec            i_right,
    output krd_pkg::t_rec            o_rec
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    krd_pkg::t_rec r_rec;
    krd_pkg::t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        case (i_ctl.cmd)
            krd_pkg::CMD_PUSH_HEAD: n_rec = i_left;
            krd_pkg::CMD_PUSH_TAIL: begin
                if (i_pos == MY_IDX) n_rec = i_ctl.rec;
            end
            krd_pkg::CMD_ROTATE:    n_rec = i_right;
            krd_pkg::CMD_DROP: begin
                if (MY_IDX >= i_pos) n_rec = i_right;
            end
            default:                n_rec = r_rec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule
